// ===== sv/fcx_pkg.sv =====
// Shared constants, codes and types for the coefficient crossfade FIR filter.
// No dependencies; used by the top level and the checker.
package fcx_pkg;

  localparam int MAX_TAPS  = 256;
  localparam int ADDR_W    = $clog2(MAX_TAPS);
  localparam int LEN_W     = ADDR_W + 1;
  localparam int SAMPLE_W  = 16;
  localparam int COEF_W    = 16;
  localparam int LERP_W    = 16;
  localparam int TLEN_W    = 10;
  localparam int PROD_W    = SAMPLE_W + COEF_W;
  localparam int ACC_W     = 40;
  localparam int TAP_GROUP = 8;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_LOAD   = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_SAMPLE = 2'd0,
    ST_ACCEPT = 2'd1,
    ST_REJECT = 2'd2
  } status_t;

  typedef enum logic [6:0] {
    S_CLR   = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_PAD   = 7'b0000100,
    S_GLIDE = 7'b0001000,
    S_COPY  = 7'b0010000,
    S_CONV  = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

endpackage

// ===== sv/fcx_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module fcx_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== sv/fir_filter_coef_crossfade_unit.sv =====
// Top level of the FIR filter with gliding coefficients: sequencer, datapath
// and three fcx_ram instances (delay line, current and target coefficients). Uses fcx_pkg.
//
//  channel | direction | tdata                                   | tuser / tlast
//  in_     | slave     | sample, lerp, coef_index, value, length | tuser op, tlast coef_last
//  out_    | master    | sample_out                              | tuser status, settled
//
// After reset a clearing pass zeroes all MAX_TAPS (256) words of all three RAMs; no request
// is taken meanwhile. A load writes the target RAM; a last word also zeroes the tail padding.
// A settled sample runs one convolution pass over len taps; while gliding, a glide pass
// over span taps comes first, then a copy pass if all taps are close (one tap a cycle).
// A new request is accepted while the previous result still waits in the output register.
module fir_filter_coef_crossfade_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,  // sample_in, lerp_factor, coef_index, coef_value,
                                 // target_length, zero fill
  input  logic        in_tuser,  // op
  input  logic        in_tlast,  // coef_last
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata, // sample_out
  output logic [2:0]  out_tuser  // status, settled
);

  localparam int AW = fcx_pkg::ADDR_W;
  localparam int LW = fcx_pkg::LEN_W;
  localparam int SW = fcx_pkg::SAMPLE_W;
  localparam int CW = fcx_pkg::COEF_W;
  localparam int PW = fcx_pkg::PROD_W;
  localparam int XW = fcx_pkg::ACC_W;
  localparam int TW = fcx_pkg::TLEN_W;
  localparam int GW = 2 * CW + 3;

  // request fields
  logic signed [SW-1:0] f_sample;
  logic [15:0]          f_lerp;
  logic [AW-1:0]        f_idx;
  logic signed [CW-1:0] f_value;
  logic [TW-1:0]        f_tlen;
  assign f_sample = in_tdata[15:0];
  assign f_lerp   = in_tdata[31:16];
  assign f_idx    = in_tdata[39:32];
  assign f_value  = in_tdata[55:40];
  assign f_tlen   = in_tdata[65:56];

  fcx_pkg::state_t state_r, state_nxt;
  logic [LW-1:0]   cnt_r, cnt_nxt, len_r, len_nxt;
  logic            p_vld_r, p_vld_nxt, q_vld_r, q_vld_nxt;
  logic [AW-1:0]   p_idx_r, p_idx_nxt;
  logic signed [PW-1:0] prod_r, prod_nxt;
  logic [XW-1:0]   acc_r, acc_nxt;
  logic            close_r, close_nxt;
  logic [AW-1:0]   wp_r, wp_nxt;
  logic [LW-1:0]   act_r, act_nxt, pend_r, pend_nxt;
  logic            settled_r, settled_nxt;
  logic [15:0]     lerp_r, lerp_nxt;
  logic [LW-1:0]   pad_i_r, pad_i_nxt, pad_end_r, pad_end_nxt;
  logic [SW-1:0]   res_smp_r, res_smp_nxt;
  fcx_pkg::status_t res_st_r, res_st_nxt;
  logic            out_vld_r, out_vld_nxt;
  logic [SW-1:0]   out_smp_r, out_smp_nxt;
  logic [1:0]      out_st_r, out_st_nxt;
  logic            out_set_r, out_set_nxt;

  // RAM ports
  logic          cur_we, tgt_we, dly_we;
  logic [AW-1:0] cur_wa, tgt_wa, dly_wa, dly_ra;
  logic [CW-1:0] cur_wd, tgt_wd, cur_rd, tgt_rd;
  logic [SW-1:0] dly_wd, dly_rd;

  fcx_ram #(.WIDTH(CW), .DEPTH(fcx_pkg::MAX_TAPS)) u_cur (
    .clk(clk), .wr_en(cur_we), .wr_addr(cur_wa), .wr_data(cur_wd),
    .rd_addr(cnt_r[AW-1:0]), .rd_data(cur_rd)
  );
  fcx_ram #(.WIDTH(CW), .DEPTH(fcx_pkg::MAX_TAPS)) u_tgt (
    .clk(clk), .wr_en(tgt_we), .wr_addr(tgt_wa), .wr_data(tgt_wd),
    .rd_addr(cnt_r[AW-1:0]), .rd_data(tgt_rd)
  );
  fcx_ram #(.WIDTH(SW), .DEPTH(fcx_pkg::MAX_TAPS)) u_dly (
    .clk(clk), .wr_en(dly_we), .wr_addr(dly_wa), .wr_data(dly_wd),
    .rd_addr(dly_ra), .rd_data(dly_rd)
  );
  assign dly_ra = wp_r + cnt_r[AW-1:0];

  // glide arithmetic on the tap that came back from the RAMs
  logic signed [CW-1:0] t_eff, cur_s;
  logic signed [CW:0]   diff, gap;
  logic signed [GW-1:0] gprod;
  logic signed [CW+2:0] step, cnew;
  logic                 tap_ok;
  assign t_eff = ({1'b0, p_idx_r} < pend_r) ? $signed(tgt_rd) : '0;
  assign cur_s = $signed(cur_rd);
  assign diff  = {t_eff[CW-1], t_eff} - {cur_s[CW-1], cur_s};
  assign gprod = GW'(diff) * GW'($signed({1'b0, lerp_r}));
  // round to nearest, ties up
  assign step  = gprod[GW-1:16] + {{(CW+2){1'b0}}, gprod[15]};
  assign cnew  = {{3{cur_s[CW-1]}}, cur_s} + step;
  assign gap   = {t_eff[CW-1], t_eff} - {cnew[CW-1], cnew[CW-1:0]};
  assign tap_ok = (gap <= 1) && (gap >= -1);

  // output rounding and saturation
  logic signed [XW-15:0] rnd;
  logic signed [SW-1:0]  sat;
  assign rnd = {acc_r[XW-1], acc_r[XW-1:CW-1]} + {{(XW-15){1'b0}}, acc_r[CW-2]};
  always_comb begin
    if (rnd > $signed({{(XW-13-SW){1'b0}}, {(SW-1){1'b1}}})) begin
      sat = {1'b0, {(SW-1){1'b1}}};
    end else if (rnd < $signed({{(XW-14-SW){1'b1}}, 1'b1, {(SW-1){1'b0}}})) begin
      sat = {1'b1, {(SW-1){1'b0}}};
    end else begin
      sat = rnd[SW-1:0];
    end
  end

  logic [TW:0]    padded;
  logic [LW-1:0]  span;
  logic           accept, pass_end, out_free;
  assign padded   = ({1'b0, f_tlen} + (TW+1)'(fcx_pkg::TAP_GROUP - 1))
                    & ~(TW+1)'(fcx_pkg::TAP_GROUP - 1);
  assign span     = (act_r > pend_r) ? act_r : pend_r;
  assign accept   = in_tvalid && in_tready;
  assign pass_end = (cnt_r == len_r) && !p_vld_r && !q_vld_r;
  assign out_free = !out_vld_r || out_tready;

  assign in_tready = (state_r == fcx_pkg::S_IDLE);

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    len_nxt     = len_r;
    p_vld_nxt   = 1'b0;
    p_idx_nxt   = p_idx_r;
    q_vld_nxt   = 1'b0;
    prod_nxt    = prod_r;
    acc_nxt     = acc_r;
    close_nxt   = close_r;
    wp_nxt      = wp_r;
    act_nxt     = act_r;
    pend_nxt    = pend_r;
    settled_nxt = settled_r;
    lerp_nxt    = lerp_r;
    pad_i_nxt   = pad_i_r;
    pad_end_nxt = pad_end_r;
    res_smp_nxt = res_smp_r;
    res_st_nxt  = res_st_r;
    out_vld_nxt = out_vld_r && !out_tready;
    out_smp_nxt = out_smp_r;
    out_st_nxt  = out_st_r;
    out_set_nxt = out_set_r;
    cur_we = 1'b0; cur_wa = p_idx_r;          cur_wd = '0;
    tgt_we = 1'b0; tgt_wa = f_idx;            tgt_wd = f_value;
    dly_we = 1'b0; dly_wa = wp_r;             dly_wd = f_sample;

    // tap issue shared by the three passes
    if ((state_r == fcx_pkg::S_GLIDE || state_r == fcx_pkg::S_COPY ||
         state_r == fcx_pkg::S_CONV) && cnt_r < len_r) begin
      cnt_nxt   = cnt_r + 1'b1;
      p_vld_nxt = 1'b1;
      p_idx_nxt = cnt_r[AW-1:0];
    end

    unique case (state_r)
      fcx_pkg::S_CLR: begin
        cur_we = 1'b1; tgt_we = 1'b1; dly_we = 1'b1;
        cur_wa = cnt_r[AW-1:0]; tgt_wa = cnt_r[AW-1:0]; dly_wa = cnt_r[AW-1:0];
        tgt_wd = '0; dly_wd = '0;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r[AW-1:0] == {AW{1'b1}}) begin
          state_nxt = fcx_pkg::S_IDLE;
        end
      end
      fcx_pkg::S_IDLE: begin
        if (accept && in_tuser == fcx_pkg::OP_LOAD) begin
          res_smp_nxt = '0;
          if (padded > (TW+1)'(fcx_pkg::MAX_TAPS)) begin
            res_st_nxt = fcx_pkg::ST_REJECT;
            state_nxt  = fcx_pkg::S_DONE;
          end else begin
            res_st_nxt = fcx_pkg::ST_ACCEPT;
            tgt_we     = 1'b1;
            if (in_tlast) begin
              pend_nxt    = padded[LW-1:0];
              settled_nxt = 1'b0;
              pad_i_nxt   = f_tlen[LW-1:0];
              pad_end_nxt = padded[LW-1:0];
              state_nxt   = fcx_pkg::S_PAD;
            end else begin
              state_nxt = fcx_pkg::S_DONE;
            end
          end
        end else if (accept) begin
          dly_we   = 1'b1;
          lerp_nxt = f_lerp;
          cnt_nxt  = '0;
          acc_nxt  = '0;
          close_nxt = 1'b1;
          if (settled_r) begin
            len_nxt   = act_r;
            state_nxt = fcx_pkg::S_CONV;
          end else begin
            len_nxt   = span;
            state_nxt = fcx_pkg::S_GLIDE;
          end
        end
      end
      fcx_pkg::S_PAD: begin
        // zero the tail of the last group
        if (pad_i_r < pad_end_r) begin
          tgt_we    = 1'b1;
          tgt_wa    = pad_i_r[AW-1:0];
          tgt_wd    = '0;
          pad_i_nxt = pad_i_r + 1'b1;
        end else begin
          state_nxt = fcx_pkg::S_DONE;
        end
      end
      fcx_pkg::S_GLIDE: begin
        if (p_vld_r) begin
          cur_we = 1'b1;
          cur_wd = cnew[CW-1:0];
          close_nxt = close_r && tap_ok;
        end
        if (pass_end) begin
          cnt_nxt = '0;
          if (close_r) begin
            state_nxt = fcx_pkg::S_COPY;
          end else begin
            len_nxt   = span;
            state_nxt = fcx_pkg::S_CONV;
          end
        end
      end
      fcx_pkg::S_COPY: begin
        if (p_vld_r) begin
          cur_we = 1'b1;
          cur_wd = t_eff;
        end
        if (pass_end) begin
          act_nxt     = pend_r;
          settled_nxt = 1'b1;
          cnt_nxt     = '0;
          len_nxt     = pend_r;
          state_nxt   = fcx_pkg::S_CONV;
        end
      end
      fcx_pkg::S_CONV: begin
        if (p_vld_r) begin
          q_vld_nxt = 1'b1;
          prod_nxt  = PW'($signed(cur_rd)) * PW'($signed(dly_rd));
        end
        if (q_vld_r) begin
          acc_nxt = acc_r + {{(XW-PW){prod_r[PW-1]}}, prod_r};
        end
        if (pass_end) begin
          res_smp_nxt = sat;
          res_st_nxt  = fcx_pkg::ST_SAMPLE;
          wp_nxt      = wp_r - 1'b1;
          state_nxt   = fcx_pkg::S_DONE;
        end
      end
      fcx_pkg::S_DONE: begin
        if (out_free) begin
          out_vld_nxt = 1'b1;
          out_smp_nxt = res_smp_r;
          out_st_nxt  = res_st_r;
          out_set_nxt = settled_r;
          state_nxt   = fcx_pkg::S_IDLE;
        end
      end
      default: state_nxt = fcx_pkg::S_CLR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= fcx_pkg::S_CLR;
      cnt_r     <= '0;
      len_r     <= '0;
      p_vld_r   <= 1'b0;
      q_vld_r   <= 1'b0;
      wp_r      <= AW'(fcx_pkg::MAX_TAPS - 1);
      act_r     <= '0;
      pend_r    <= '0;
      settled_r <= 1'b1;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      len_r     <= len_nxt;
      p_vld_r   <= p_vld_nxt;
      q_vld_r   <= q_vld_nxt;
      wp_r      <= wp_nxt;
      act_r     <= act_nxt;
      pend_r    <= pend_nxt;
      settled_r <= settled_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p_idx_r   <= p_idx_nxt;
    prod_r    <= prod_nxt;
    acc_r     <= acc_nxt;
    close_r   <= close_nxt;
    lerp_r    <= lerp_nxt;
    pad_i_r   <= pad_i_nxt;
    pad_end_r <= pad_end_nxt;
    res_smp_r <= res_smp_nxt;
    res_st_r  <= res_st_nxt;
    out_smp_r <= out_smp_nxt;
    out_st_r  <= out_st_nxt;
    out_set_r <= out_set_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_smp_r;
  assign out_tuser  = {out_set_r, out_st_r};

endmodule

// ===== sv/fcx_checker.sv =====
// Port-level assertions for the crossfade FIR filter, bound to the top level.
// Uses fcx_pkg for the status codes.
module fcx_port_props (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic [2:0]  out_tuser
);

  // a held result keeps its payload
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // clearing pass after reset takes no request
  a_clr: assert property (@(posedge clk) !rst_n |=> !in_tready)
    else $error("request taken during clearing pass");

  a_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser[1:0] == fcx_pkg::ST_SAMPLE ||
                    out_tuser[1:0] == fcx_pkg::ST_ACCEPT ||
                    out_tuser[1:0] == fcx_pkg::ST_REJECT))
    else $error("bad status code");

  // load results carry a zero sample
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1:0] != fcx_pkg::ST_SAMPLE |-> out_tdata == 16'd0)
    else $error("load result with nonzero sample");

endmodule

bind fir_filter_coef_crossfade_unit fcx_port_props u_fcx_port_props (
  .clk(clk), .rst_n(rst_n), .in_tready(in_tready), .out_tvalid(out_tvalid),
  .out_tready(out_tready), .out_tdata(out_tdata), .out_tuser(out_tuser)
);
